// ===== sv/tsp_mlb_pkg.sv =====
// ----------------------------------------------------------------------------
// tsp_mlb_pkg
// Shared widths, codes and state types of the tour lower-bound block.
// ----------------------------------------------------------------------------
package tsp_mlb_pkg;

    localparam int CITY_W    = 6;
    localparam int MASK_W    = 64;
    localparam int EDGE_W    = 16;
    localparam int GH_W      = 24;
    localparam int COST_W    = 23;
    localparam int HEUR_W    = 23;
    localparam int BOUND_W   = 24;
    localparam int NODE_W    = 7;
    localparam int S_TDATA_W = 176;
    localparam int M_TDATA_W = 56;

    localparam int DEF_MAX_CITIES = 64;
    localparam int DEF_DIST_BITS  = 16;

    localparam logic [NODE_W-1:0]  NODE_RST    = 7'd64;
    localparam logic [GH_W-1:0]    GH_COMPUTE  = 24'hFFFFFF;
    localparam logic [HEUR_W-1:0]  HEUR_MAX    = 23'h7FFFFF;
    localparam logic [BOUND_W-1:0] BOUND_MAX   = 24'hFFFFFF;

    // tuser codes of the input word
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_EVAL = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BUILD,
        S_PASS,
        S_SWAP0,
        S_SWAP1,
        S_SREAD,
        S_SWAIT,
        S_SUM,
        S_TOTAL
    } t_state;

    typedef enum logic [1:0] {
        MODE_PRIM,
        MODE_TOSET,
        MODE_BACK
    } t_mode;

endpackage

// ===== sv/tsp_mst_lower_bound.sv =====
// ----------------------------------------------------------------------------
// tsp_mst_lower_bound
// Lower bound of a partial TSP tour from a Prim spanning tree over the
// cities still to visit, with the distance table held in block RAM.
// ----------------------------------------------------------------------------
// A load word (tuser 0) writes one distance entry. An evaluate word
// (tuser 1) yields one result word; a given heuristic goes straight to
// the total. Otherwise, with n cities and c of them unvisited, a scan of
// the n cities builds the visit order, then one Prim pass runs for each
// joined count j from 1 to c-1, each followed by the swap states S_SWAP0
// and S_SWAP1, then two passes over the tree find the nearest edges (the
// second is a single read when an exit city is given). With no city left,
// a single read of the edge from the tail city to city 0 gives the
// heuristic. The passes are paced by the single read port of the distance
// RAM, one entry per cycle, behind the visit-order RAM that supplies the
// city of each position. The output word sits in a register, so the next
// word is taken while a result still waits.
// ----------------------------------------------------------------------------
module tsp_mst_lower_bound #(
    parameter int MAX_CITIES = tsp_mlb_pkg::DEF_MAX_CITIES,
    parameter int DIST_BITS  = tsp_mlb_pkg::DEF_DIST_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // row_city, col_city, edge_length, visited_mask, tail_city, exit_city,
    // given_heuristic, path_cost, parent_bound, zero pad
    input  logic [tsp_mlb_pkg::S_TDATA_W-1:0]   i_s_tdata,
    // action
    input  logic                                i_s_tuser,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // heuristic, total_bound, exit_choice, zero pad
    output logic [tsp_mlb_pkg::M_TDATA_W-1:0]   o_m_tdata,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tsp_mlb_pkg::NODE_W-1:0]      i_cfg_data
);
    import tsp_mlb_pkg::*;

    localparam int PW  = (MAX_CITIES > 1) ? $clog2(MAX_CITIES) : 1;
    localparam int NW  = $clog2(MAX_CITIES + 1);
    localparam int DD  = MAX_CITIES * MAX_CITIES;
    localparam int AW  = $clog2(DD);
    localparam int KW  = DIST_BITS + 1;
    localparam int LW  = CITY_W + DIST_BITS;
    localparam int SW  = DIST_BITS + CITY_W + 2;
    localparam logic [KW-1:0] KEY_INF = KW'(1) << DIST_BITS;

    function automatic logic [AW-1:0] f_daddr(input logic [CITY_W-1:0] r,
                                              input logic [CITY_W-1:0] c);
        f_daddr = AW'(int'(r) * MAX_CITIES + int'(c));
    endfunction

    function automatic logic f_oob(input logic [CITY_W-1:0] c);
        f_oob = (int'(c) >= MAX_CITIES);
    endfunction

    // input fields
    logic [CITY_W-1:0]  w_row, w_col, w_last, w_exit;
    logic [EDGE_W-1:0]  w_edge;
    logic [MASK_W-1:0]  w_vis;
    logic [GH_W-1:0]    w_gh;
    logic [COST_W-1:0]  w_cost;
    logic [BOUND_W-1:0] w_pbound;

    assign w_row    = i_s_tdata[5:0];
    assign w_col    = i_s_tdata[11:6];
    assign w_edge   = i_s_tdata[27:12];
    assign w_vis    = i_s_tdata[91:28];
    assign w_last   = i_s_tdata[97:92];
    assign w_exit   = i_s_tdata[103:98];
    assign w_gh     = i_s_tdata[127:104];
    assign w_cost   = i_s_tdata[150:128];
    assign w_pbound = i_s_tdata[174:151];

    // registers
    t_state             r_state, n_state;
    logic [NODE_W-1:0]  r_node_count;
    logic [MASK_W-1:0]  r_vis, n_vis;
    logic [CITY_W-1:0]  r_last, n_last, r_exit, n_exit;
    logic [COST_W-1:0]  r_cost, n_cost;
    logic [BOUND_W-1:0] r_pbound, n_pbound;
    logic [NW-1:0]      r_scan, n_scan, r_cnt, n_cnt, r_joined, n_joined;
    logic [CITY_W-1:0]  r_order0, n_order0, r_row, n_row, r_col, n_col;
    t_mode              r_mode, n_mode;
    logic               r_first, n_first;
    logic [NW-1:0]      r_pos, n_pos, r_p1, n_p1, r_p2, n_p2;
    logic               r_issue, n_issue, r_v1, n_v1, r_v2, n_v2;
    logic [LW-1:0]      r_ent2, n_ent2, r_head, n_head;
    logic [KW-1:0]      r_minv, n_minv, r_toset, n_toset, r_back, n_back;
    logic [NW-1:0]      r_minpos, n_minpos;
    logic [CITY_W-1:0]  r_mincity, n_mincity, r_choice, n_choice;
    logic [SW-1:0]      r_tree, n_tree;
    logic               r_noleft, n_noleft;
    logic [HEUR_W-1:0]  r_heur, n_heur;
    logic               r_out_valid, n_out_valid;
    logic [M_TDATA_W-1:0] r_out_data, n_out_data;

    // memory ports
    logic                 w_d_we;
    logic [AW-1:0]        w_d_waddr, w_d_raddr;
    logic [DIST_BITS-1:0] w_d_wdata, w_d_rdata;
    logic                 w_l_we;
    logic [PW-1:0]        w_l_waddr;
    logic [LW-1:0]        w_l_wdata, w_l_rdata;

    // helpers
    logic               w_in_acc, w_pass_done, w_out_free;
    logic [NW-1:0]      w_n;
    logic [DIST_BITS-1:0] w_d, w_key;
    logic [NW-1:0]      w_jn;
    logic [SW:0]        w_sum;
    logic [BOUND_W-1:0] w_tot;

    assign w_in_acc    = i_s_tvalid && o_s_tready;
    assign w_pass_done = !r_issue && !r_v1 && !r_v2;
    assign w_out_free  = !r_out_valid || i_m_tready;
    assign w_jn        = NW'(r_joined + 1'b1);

    // clamp city count to between 2 and the table size
    always_comb begin
        if (r_node_count < NODE_W'(2)) begin
            w_n = NW'(2);
        end else if (int'(r_node_count) > MAX_CITIES) begin
            w_n = NW'(MAX_CITIES);
        end else begin
            w_n = NW'(r_node_count);
        end
    end

    // distance read value and updated Prim key
    assign w_d   = f_oob(r_row) ? '0 : w_d_rdata;
    assign w_key = (r_first || (w_d < r_ent2[DIST_BITS-1:0])) ? w_d
                                                               : r_ent2[DIST_BITS-1:0];

    // distance table: load words write, passes and single reads read
    assign w_d_we    = w_in_acc && (i_s_tuser == ACT_LOAD) && !f_oob(w_row) && !f_oob(w_col);
    assign w_d_waddr = f_daddr(w_row, w_col);
    assign w_d_wdata = DIST_BITS'(w_edge);
    assign w_d_raddr = (r_state == S_SREAD) ? f_daddr(r_row, r_col)
                                            : f_daddr(r_row, w_l_rdata[LW-1:DIST_BITS]);

    tsp_mlb_ram #(
        .WIDTH (DIST_BITS),
        .DEPTH (DD)
    ) u_dist_ram (
        .i_clk   (i_clk),
        .i_we    (w_d_we),
        .i_waddr (w_d_waddr),
        .i_wdata (w_d_wdata),
        .i_raddr (w_d_raddr),
        .o_rdata (w_d_rdata)
    );

    // visit order with Prim keys, one entry per position
    always_comb begin
        w_l_we    = 1'b0;
        w_l_waddr = r_cnt[PW-1:0];
        w_l_wdata = {r_scan[CITY_W-1:0], {DIST_BITS{1'b0}}};
        case (r_state)
            S_BUILD: begin
                w_l_we = (r_scan != w_n) && !r_vis[r_scan[CITY_W-1:0]];
            end
            S_PASS: begin
                w_l_we    = r_v2 && (r_mode == MODE_PRIM);
                w_l_waddr = r_p2[PW-1:0];
                w_l_wdata = {r_ent2[LW-1:DIST_BITS], w_key};
            end
            S_SWAP0: begin
                w_l_we    = 1'b1;
                w_l_waddr = r_minpos[PW-1:0];
                w_l_wdata = r_head;
            end
            S_SWAP1: begin
                w_l_we    = 1'b1;
                w_l_waddr = r_joined[PW-1:0];
                w_l_wdata = {r_mincity, r_minv[DIST_BITS-1:0]};
            end
            default: begin
                w_l_we = 1'b0;
            end
        endcase
    end

    tsp_mlb_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_CITIES)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (w_l_we),
        .i_waddr (w_l_waddr),
        .i_wdata (w_l_wdata),
        .i_raddr (r_pos[PW-1:0]),
        .o_rdata (w_l_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc && (i_s_tuser == ACT_EVAL)) begin
                    n_state = (w_gh == GH_COMPUTE) ? S_BUILD : S_TOTAL;
                end
            end
            S_BUILD: begin
                if (r_scan == w_n) begin
                    n_state = (r_cnt == '0) ? S_SREAD : S_PASS;
                end
            end
            S_PASS: begin
                if (w_pass_done) begin
                    case (r_mode)
                        MODE_PRIM:  n_state = S_SWAP0;
                        MODE_TOSET: n_state = (r_exit == r_last) ? S_PASS : S_SREAD;
                        default:    n_state = S_SUM;
                    endcase
                end
            end
            S_SWAP0: n_state = S_SWAP1;
            S_SWAP1: n_state = S_PASS;
            S_SREAD: n_state = S_SWAIT;
            S_SWAIT: n_state = r_noleft ? S_TOTAL : S_SUM;
            S_SUM:   n_state = S_TOTAL;
            S_TOTAL: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and pass engine
    always_comb begin
        n_vis       = r_vis;
        n_last      = r_last;
        n_exit      = r_exit;
        n_cost      = r_cost;
        n_pbound    = r_pbound;
        n_scan      = r_scan;
        n_cnt       = r_cnt;
        n_joined    = r_joined;
        n_order0    = r_order0;
        n_row       = r_row;
        n_col       = r_col;
        n_mode      = r_mode;
        n_first     = r_first;
        n_pos       = r_pos;
        n_issue     = r_issue;
        n_p1        = r_p1;
        n_p2        = r_p1;
        n_v2        = r_v1;
        n_ent2      = w_l_rdata;
        n_head      = r_head;
        n_minv      = r_minv;
        n_minpos    = r_minpos;
        n_mincity   = r_mincity;
        n_toset     = r_toset;
        n_back      = r_back;
        n_choice    = r_choice;
        n_tree      = r_tree;
        n_noleft    = r_noleft;
        n_heur      = r_heur;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_data  = r_out_data;
        n_v1        = 1'b0;
        w_sum       = '0;
        w_tot       = '0;

        // issue one position a cycle
        if (r_issue) begin
            n_v1 = 1'b1;
            n_p1 = r_pos;
            n_pos = NW'(r_pos + 1'b1);
            if (NW'(r_pos + 1'b1) == r_cnt) begin
                n_issue = 1'b0;
            end
        end

        // fold in the distance that comes back
        if (r_v2) begin
            case (r_mode)
                MODE_PRIM: begin
                    if ({1'b0, w_key} < r_minv) begin
                        n_minv    = {1'b0, w_key};
                        n_minpos  = r_p2;
                        n_mincity = r_ent2[LW-1:DIST_BITS];
                    end
                    if (r_p2 == r_joined) begin
                        n_head = {r_ent2[LW-1:DIST_BITS], w_key};
                    end
                end
                MODE_TOSET: begin
                    if ({1'b0, w_d} < r_toset) begin
                        n_toset = {1'b0, w_d};
                    end
                end
                default: begin
                    if ({1'b0, w_d} < r_back) begin
                        n_back   = {1'b0, w_d};
                        n_choice = r_ent2[LW-1:DIST_BITS];
                    end
                end
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_acc && (i_s_tuser == ACT_EVAL)) begin
                    n_vis    = w_vis;
                    n_last   = w_last;
                    n_exit   = w_exit;
                    n_cost   = w_cost;
                    n_pbound = w_pbound;
                    n_scan   = '0;
                    n_cnt    = '0;
                    n_heur   = w_gh[GH_W-1] ? '0 : w_gh[HEUR_W-1:0];
                    n_choice = w_exit;
                end
            end
            S_BUILD: begin
                if (r_scan != w_n) begin
                    // append each unvisited city to the visit order
                    n_scan = NW'(r_scan + 1'b1);
                    if (!r_vis[r_scan[CITY_W-1:0]]) begin
                        n_cnt = NW'(r_cnt + 1'b1);
                        if (r_cnt == '0) begin
                            n_order0 = r_scan[CITY_W-1:0];
                        end
                    end
                end else if (r_cnt == '0) begin
                    n_noleft = 1'b1;
                    n_row    = r_last;
                    n_col    = '0;
                end else begin
                    n_noleft = 1'b0;
                    n_tree   = '0;
                    n_joined = NW'(1);
                    n_first  = 1'b1;
                    n_minv   = KEY_INF;
                    n_toset  = KEY_INF;
                    n_issue  = 1'b1;
                    if (r_cnt == NW'(1)) begin
                        n_mode = MODE_TOSET;
                        n_row  = r_last;
                        n_pos  = '0;
                    end else begin
                        n_mode = MODE_PRIM;
                        n_row  = r_order0;
                        n_pos  = NW'(1);
                    end
                end
            end
            S_PASS: begin
                if (w_pass_done) begin
                    case (r_mode)
                        MODE_PRIM: begin
                            n_tree = SW'(r_tree + SW'(r_minv[DIST_BITS-1:0]));
                        end
                        MODE_TOSET: begin
                            if (r_exit == r_last) begin
                                n_mode   = MODE_BACK;
                                n_row    = '0;
                                n_back   = KEY_INF;
                                n_choice = r_order0;
                                n_pos    = '0;
                                n_issue  = 1'b1;
                            end else begin
                                n_row = '0;
                                n_col = r_exit;
                            end
                        end
                        default: begin
                            n_noleft = 1'b0;
                        end
                    endcase
                end
            end
            S_SWAP1: begin
                // join the chosen city and scan on from it
                n_joined = w_jn;
                n_first  = 1'b0;
                n_issue  = 1'b1;
                if (w_jn < r_cnt) begin
                    n_mode = MODE_PRIM;
                    n_row  = r_mincity;
                    n_minv = KEY_INF;
                    n_pos  = w_jn;
                end else begin
                    n_mode  = MODE_TOSET;
                    n_row   = r_last;
                    n_toset = KEY_INF;
                    n_pos   = '0;
                end
            end
            S_SWAIT: begin
                if (r_noleft) begin
                    n_heur   = (f_oob(r_row) || f_oob(r_col)) ? '0 : HEUR_W'(w_d_rdata);
                    n_choice = r_last;
                end else begin
                    n_back   = (f_oob(r_row) || f_oob(r_col)) ? '0 : {1'b0, w_d_rdata};
                    n_choice = r_exit;
                end
            end
            S_SUM: begin
                w_sum  = (SW+1)'({1'b0, r_tree} + (SW+1)'(r_toset) + (SW+1)'(r_back));
                n_heur = (w_sum > (SW+1)'(HEUR_MAX)) ? HEUR_MAX : HEUR_W'(w_sum);
            end
            S_TOTAL: begin
                w_tot = BOUND_W'({1'b0, r_cost} + {1'b0, r_heur});
                if (w_tot < r_pbound) begin
                    w_tot = r_pbound;
                end
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {3'b000, r_choice, w_tot, r_heur};
                end
            end
            default: begin
                n_noleft = r_noleft;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_node_count <= NODE_RST;
            r_issue      <= 1'b0;
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_issue     <= n_issue;
            r_v1        <= n_v1;
            r_v2        <= n_v2;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_node_count <= i_cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_vis      <= n_vis;
        r_last     <= n_last;
        r_exit     <= n_exit;
        r_cost     <= n_cost;
        r_pbound   <= n_pbound;
        r_scan     <= n_scan;
        r_cnt      <= n_cnt;
        r_joined   <= n_joined;
        r_order0   <= n_order0;
        r_row      <= n_row;
        r_col      <= n_col;
        r_mode     <= n_mode;
        r_first    <= n_first;
        r_pos      <= n_pos;
        r_p1       <= n_p1;
        r_p2       <= n_p2;
        r_ent2     <= n_ent2;
        r_head     <= n_head;
        r_minv     <= n_minv;
        r_minpos   <= n_minpos;
        r_mincity  <= n_mincity;
        r_toset    <= n_toset;
        r_back     <= n_back;
        r_choice   <= n_choice;
        r_tree     <= n_tree;
        r_noleft   <= n_noleft;
        r_heur     <= n_heur;
        r_out_data <= n_out_data;
    end

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;
    assign o_cfg_ready = 1'b1;

    // checks
    a_dist_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_d_we |-> (r_state == S_IDLE))
        else $error("distance table written outside idle");

    a_pipe_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> $past(r_v1))
        else $error("pass pipeline stage two without stage one");

    a_swap_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWAP0) |-> ((r_minpos >= r_joined) && (r_minpos < r_cnt)))
        else $error("swap position outside the unjoined range");

    a_result_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TOTAL && w_out_free) |=> r_out_valid)
        else $error("result not loaded into the output register");

endmodule

// ===== sv/tsp_mlb_ram.sv =====
// ----------------------------------------------------------------------------
// tsp_mlb_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tsp_mlb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== tb/sv/tb_tsp_bound_checker.sv =====
// ----------------------------------------------------------------------------
// tb_tsp_bound_checker
// Watches the stream and config channels of the tour lower-bound block. It
// keeps its own copy of the distance table and city count and predicts each
// result word. Each result word is then compared field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_tsp_bound_checker
    import tsp_mlb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    input  logic                 i_s_tuser,
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [M_TDATA_W-1:0] i_m_tdata,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [NODE_W-1:0]    i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    localparam int DIST_INF = 1 << DEF_DIST_BITS;

    typedef struct packed {
        logic [CITY_W-1:0]  exit_city;
        logic [BOUND_W-1:0] total;
        logic [HEUR_W-1:0]  heur;
    } t_bound;

    logic [EDGE_W-1:0] dist_copy [0:4095];
    logic [NODE_W-1:0] city_count;
    t_bound            bound_fifo [$];
    int                fails;

    assign o_fail_count = fails;

    function automatic int edge_at(int r, int c);
        return dist_copy[r * 64 + c];
    endfunction

    // Compute the heuristic, bound and exit city of one partial tour
    function automatic t_bound predict_bound(logic [S_TDATA_W-1:0] w);
        logic [MASK_W-1:0] visited;
        int last, exitc, n, cnt, joined, minv, minpos, to_set, back, choice, from, d, t;
        longint heur, tree_len, total;
        logic [GH_W-1:0] gh;
        int order [64];
        int link  [64];
        t_bound r;
        visited = w[91:28];
        last    = w[97:92];
        exitc   = w[103:98];
        gh      = w[127:104];
        if (gh != GH_COMPUTE) begin
            heur   = gh[GH_W-1] ? 0 : gh;
            choice = exitc;
        end else begin
            n = city_count;
            if (n < 2) n = 2;
            if (n > 64) n = 64;
            cnt = 0;
            for (int i = 0; i < n; i++) begin
                if (!visited[i]) begin
                    order[cnt] = i;
                    cnt++;
                end
            end
            if (cnt == 0) begin
                heur   = edge_at(last, 0);
                choice = last;
            end else begin
                // Grow the tree in visit order, swapping each join forward
                joined = 1; minv = DIST_INF; minpos = 0; tree_len = 0;
                for (int i = 1; i < cnt; i++) begin
                    link[i] = edge_at(order[0], order[i]);
                    if (link[i] < minv) begin
                        minv = link[i]; minpos = i;
                    end
                end
                while (joined < cnt) begin
                    tree_len += minv;
                    t = order[minpos]; order[minpos] = order[joined]; order[joined] = t;
                    t = link[minpos]; link[minpos] = link[joined]; link[joined] = t;
                    joined++;
                    from = order[joined-1];
                    minv = DIST_INF; minpos = 0;
                    for (int i = joined; i < cnt; i++) begin
                        d = edge_at(from, order[i]);
                        if (link[i] > d) link[i] = d;
                        if (link[i] < minv) begin
                            minv = link[i]; minpos = i;
                        end
                    end
                end
                to_set = DIST_INF;
                for (int i = 0; i < cnt; i++) begin
                    d = edge_at(last, order[i]);
                    if (d < to_set) to_set = d;
                end
                if (exitc == last) begin
                    back = DIST_INF; choice = order[0];
                    for (int i = 0; i < cnt; i++) begin
                        d = edge_at(0, order[i]);
                        if (d < back) begin
                            back = d; choice = order[i];
                        end
                    end
                end else begin
                    back   = edge_at(0, exitc);
                    choice = exitc;
                end
                heur = tree_len + to_set + back;
            end
        end
        if (heur > HEUR_MAX) heur = HEUR_MAX;
        total = heur + w[150:128];
        if (total > BOUND_MAX) total = BOUND_MAX;
        if (total < w[174:151]) total = w[174:151];
        r.heur      = heur[HEUR_W-1:0];
        r.total     = total[BOUND_W-1:0];
        r.exit_city = choice[CITY_W-1:0];
        return r;
    endfunction

    // Track table and config writes, queue predictions, compare results
    always @(posedge i_clk) begin
        t_bound got, want;
        if (!i_rst_n) begin
            city_count = NODE_RST;
            fails      = 0;
            bound_fifo.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) city_count = i_cfg_data;
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata[52:0];
                if (bound_fifo.size() == 0) begin
                    fails++;
                    $display("%0t: result word expected none actual %h", $time, got);
                end else begin
                    want = bound_fifo.pop_front();
                    if (got.heur != want.heur) begin
                        fails++;
                        $display("%0t: heuristic expected %0d actual %0d",
                                 $time, want.heur, got.heur);
                    end
                    if (got.total != want.total) begin
                        fails++;
                        $display("%0t: total_bound expected %0d actual %0d",
                                 $time, want.total, got.total);
                    end
                    if (got.exit_city != want.exit_city) begin
                        fails++;
                        $display("%0t: exit_choice expected %0d actual %0d",
                                 $time, want.exit_city, got.exit_city);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser == ACT_LOAD)
                    dist_copy[i_s_tdata[5:0] * 64 + i_s_tdata[11:6]] = i_s_tdata[27:12];
                else
                    bound_fifo.push_back(predict_bound(i_s_tdata));
            end
        end
        o_pending = bound_fifo.size();
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the tour lower-bound block: fills the corner of
// the distance table that the tours touch, then runs directed and random
// partial tours over several city counts, with random idling on both sides
// and a long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
    import tsp_mlb_pkg::*;

    localparam int LIMIT       = 1500000;
    localparam int DRAIN       = 3000;
    localparam int TOUR_CITIES = 8;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tuser = ACT_LOAD;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [NODE_W-1:0]    cfg_data = '0;
    int                   fail_count, pending, cycles;
    int                   send_idle = 29, recv_idle = 62;
    bit                   hold_req = 0;
    int                   nodes = 64;

    always #6 i_clk = ~i_clk;

    tsp_mst_lower_bound dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_s_tuser(s_tuser),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready), .o_m_tdata(m_tdata),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_data(cfg_data)
    );

    tb_tsp_bound_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_s_tuser(s_tuser),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready), .i_m_tdata(m_tdata),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // End the run at the cycle limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Drive receiver ready; hold off for a long stretch on request
    always @(negedge i_clk) begin
        static int hold_left = 0;
        if (hold_req && hold_left == 0) begin
            hold_left = 4000;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Offer one word and wait for it to be taken; returns at a falling edge
    task automatic send_word(logic user, logic [S_TDATA_W-1:0] data);
        s_tvalid <= 1'b1;
        s_tuser  <= user;
        s_tdata  <= data;
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
        if ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(negedge i_clk);
        end
    endtask

    task automatic send_load(int row, int col, logic [EDGE_W-1:0] len);
        logic [S_TDATA_W-1:0] w;
        w = S_TDATA_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        w[5:0] = CITY_W'(row); w[11:6] = CITY_W'(col); w[27:12] = len; w[175] = 1'b0;
        send_word(ACT_LOAD, w);
    endtask

    task automatic send_eval(logic [MASK_W-1:0] mask, int last, int exitc,
                             logic [GH_W-1:0] gh, logic [COST_W-1:0] cost,
                             logic [BOUND_W-1:0] pb);
        logic [S_TDATA_W-1:0] w;
        w = S_TDATA_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        w[91:28] = mask; w[97:92] = CITY_W'(last); w[103:98] = CITY_W'(exitc);
        w[127:104] = gh; w[150:128] = cost; w[174:151] = pb; w[175] = 1'b0;
        send_word(ACT_EVAL, w);
    endtask

    // Drop valid, let every result arrive and the block go idle
    task automatic drain_all();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN) @(negedge i_clk);
    endtask

    task automatic write_nodes(logic [NODE_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge i_clk); while (!cfg_ready);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
        nodes = (v < 2) ? 2 : (v > 64) ? 64 : v;
    endtask

    function automatic logic [EDGE_W-1:0] rand_len();
        case ($urandom_range(9))
            0:       return 16'hFFFF;
            1:       return 16'd0;
            2:       return EDGE_W'($urandom);
            default: return EDGE_W'($urandom_range(12));
        endcase
    endfunction

    // Partial tour whose open cities, tail and exit stay in the loaded corner
    task automatic rand_eval();
        logic [MASK_W-1:0] mask;
        logic [GH_W-1:0] gh;
        int lim, last;
        lim = (nodes < TOUR_CITIES) ? nodes : TOUR_CITIES;
        mask = {$urandom, $urandom};
        mask[MASK_W-1:TOUR_CITIES] = '1;
        if ($urandom_range(9) != 0) mask[0] = 1'b1;
        if ($urandom_range(19) == 0) mask = '1;
        last = $urandom_range(lim - 1);
        gh = ($urandom_range(4) == 0) ? GH_W'($urandom) : GH_COMPUTE;
        send_eval(mask, last, $urandom_range(1) ? last : $urandom_range(TOUR_CITIES - 1),
                  gh,
                  ($urandom_range(7) == 0) ? COST_W'($urandom) : COST_W'($urandom_range(999)),
                  ($urandom_range(5) == 0) ? BOUND_W'($urandom) : BOUND_W'($urandom_range(99)));
    endtask

    initial begin
        static logic [NODE_W-1:0] counts [7] = '{5, 2, 127, 9, 0, 64, 14};
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Fill the corner of the table that every tour reads
        for (int r = 0; r < TOUR_CITIES; r++)
            for (int c = 0; c < TOUR_CITIES; c++)
                send_load(r, c, rand_len());

        // Directed tours at the reset count of 64 cities
        send_load(63, 63, 16'hFFFF);
        send_load(0, 0, 16'd0);
        send_eval('1, 7, 7, GH_COMPUTE, '0, '0);
        send_eval('1, 0, 0, GH_COMPUTE, COST_W'('1), '0);
        send_eval(64'hFFFF_FFFF_FFFF_FFFE, 3, 3, GH_COMPUTE, COST_W'(10), '0);
        send_eval(~64'h0000_0000_0000_0081, 7, 7, GH_COMPUTE, '0, '0);
        send_eval(~64'h0000_0000_0000_00F6, 3, 3, GH_COMPUTE, COST_W'(100), '0);
        send_eval(~64'h0000_0000_0000_00F6, 3, 6, GH_COMPUTE, COST_W'(100), BOUND_MAX);
        send_eval(~64'h0000_0000_0000_00FE, 0, 9, 24'd0, '0, '0);
        send_eval(64'h1, 9, 12, HEUR_MAX, COST_W'('1), '0);
        send_eval(64'h1, 9, 9, 24'h800000, COST_W'(5), '0);
        send_eval(64'h1, 9, 9, 24'hFFFFFE, COST_W'(5), BOUND_W'(3));
        send_eval(64'hFFFF_FFFF_FFFF_FF01, 0, 0, GH_COMPUTE, '0, '0);
        send_eval(64'hFFFF_FFFF_FFFF_FF00, 2, 2, GH_COMPUTE, COST_W'(7), '0);
        drain_all();

        // Random phases over several city counts and idle patterns
        for (int p = 0; p < 7; p++) begin
            send_idle = (p < 2) ? 29 : (p < 4) ? 62 : 0;
            recv_idle = (p < 2) ? 62 : (p < 4) ? 29 : 0;
            write_nodes(counts[p]);
            if (p == 4) hold_req = 1;
            for (int k = 0; k < 8; k++) begin
                if (p == 1 && k == 4) drain_all();
                if ($urandom_range(2) == 0)
                    send_load($urandom_range(TOUR_CITIES - 1),
                              $urandom_range(TOUR_CITIES - 1), rand_len());
                else
                    rand_eval();
            end
            drain_all();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
